FILE: design/vcc_pkg.sv
// ----------------------------------------------------------------------------
// vcc_pkg
// Shared types, codes and the denomination table of the vending controller.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package vcc_pkg;

   localparam int TABLE_DENOMS = 8;

   localparam logic [2:0] MODE_INSERT  = 3'd0;
   localparam logic [2:0] MODE_BUY     = 3'd1;
   localparam logic [2:0] MODE_CHANGE  = 3'd2;
   localparam logic [2:0] MODE_LOAD    = 3'd3;
   localparam logic [2:0] MODE_RESTOCK = 3'd4;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_LOW_CREDIT = 2'd1;
   localparam logic [1:0] STATUS_SOLD_OUT  = 2'd2;
   localparam logic [1:0] STATUS_SHORTFALL = 2'd3;

   localparam logic [7:0]  RESET_STOCK      = 8'd20;
   localparam logic [15:0] RESET_PRICE_SLOT0 = 16'd300;
   localparam logic [15:0] RESET_PRICE_SLOT3 = 16'd500;
   localparam logic [7:0]  RESET_COUNT_SLOT0 = 8'd5;
   localparam logic [7:0]  COUNT_MAX        = 8'd255;
   localparam logic [15:0] CREDIT_MAX       = 16'hFFFF;

   typedef struct packed {
      logic        start;
      logic [15:0] credit;
      logic [9:0]  denom;
      logic [7:0]  stock;
   } qreq_type;

   typedef struct packed {
      logic        done;
      logic [7:0]  count;
      logic [15:0] amount;
   } qrsp_type;

   function automatic logic [9:0] denom_cents(input logic [2:0] idx);
      logic [9:0] value;
      case (idx)
         3'd0:    value = 10'd5;
         3'd1:    value = 10'd10;
         3'd2:    value = 10'd25;
         3'd3:    value = 10'd50;
         3'd4:    value = 10'd100;
         3'd5:    value = 10'd200;
         3'd6:    value = 10'd500;
         3'd7:    value = 10'd1000;
         default: value = 10'd0;
      endcase
      return value;
   endfunction

endpackage

`default_nettype wire

FILE: design/vcc_quot_unit.sv
// ----------------------------------------------------------------------------
// vcc_quot_unit
// Shared coin count: largest count with count*denom <= credit and
// count <= stock, by reciprocal multiplication in the MUL, CAP and AMT phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vcc_quot_unit (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire vcc_pkg::qreq_type req,
   output vcc_pkg::qrsp_type     rsp
);
   import vcc_pkg::*;

   typedef enum logic [1:0] {PH_IDLE, PH_MUL, PH_CAP, PH_AMT} phase_type;

   phase_type   phase_ff,  phase_in;
   logic        done_ff,   done_in;
   logic [7:0]  q_ff,      q_in;
   logic [15:0] acc_ff,    acc_in;
   logic [15:0] credit_ff, credit_in;
   logic [9:0]  denom_ff,  denom_in;
   logic [7:0]  stock_ff,  stock_in;
   logic [32:0] prod_ff,   prod_in;

   logic [16:0] recip_m;
   logic [4:0]  recip_sh;
   logic [32:0] quot;
   logic [17:0] amount;

   // {shift, ceil(2^shift / denom)}; exact floor for every 16-bit credit
   function automatic logic [21:0] recip_of(input logic [9:0] denom);
      logic [21:0] value;
      case (denom)
         10'd5:    value = {5'd19, 17'd104858};
         10'd10:   value = {5'd20, 17'd104858};
         10'd25:   value = {5'd21, 17'd83887};
         10'd50:   value = {5'd22, 17'd83887};
         10'd100:  value = {5'd23, 17'd83887};
         10'd200:  value = {5'd24, 17'd83887};
         10'd500:  value = {5'd25, 17'd67109};
         10'd1000: value = {5'd26, 17'd67109};
         default:  value = 22'd0;
      endcase
      return value;
   endfunction

   always_comb begin
      {recip_sh, recip_m} = recip_of(denom_ff);
      quot   = prod_ff >> recip_sh;
      amount = 18'(q_ff) * 18'(denom_ff);

      phase_in  = phase_ff;
      done_in   = 1'b0;
      q_in      = q_ff;
      acc_in    = acc_ff;
      credit_in = credit_ff;
      denom_in  = denom_ff;
      stock_in  = stock_ff;
      prod_in   = prod_ff;

      if (req.start) begin
         phase_in  = PH_MUL;
         q_in      = 8'd0;
         acc_in    = 16'd0;
         credit_in = req.credit;
         denom_in  = req.denom;
         stock_in  = req.stock;
      end else begin
         case (phase_ff)
            PH_MUL: begin
               prod_in  = 33'(credit_ff) * 33'(recip_m);
               phase_in = PH_CAP;
            end
            PH_CAP: begin
               q_in     = (quot > 33'(stock_ff)) ? stock_ff : quot[7:0];
               phase_in = PH_AMT;
            end
            PH_AMT: begin
               acc_in   = amount[15:0];
               done_in  = 1'b1;
               phase_in = PH_IDLE;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         done_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         done_ff  <= done_in;
      end
      q_ff      <= q_in;
      acc_ff    <= acc_in;
      credit_ff <= credit_in;
      denom_ff  <= denom_in;
      stock_ff  <= stock_in;
      prod_ff   <= prod_in;
   end

   assign rsp.done   = done_ff;
   assign rsp.count  = q_ff;
   assign rsp.amount = acc_ff;

endmodule

`default_nettype wire

FILE: design/vending_credit_and_change_controller.sv
// ----------------------------------------------------------------------------
// vending_credit_and_change_controller
// Credit, coin stock and product slots with greedy change payout.
// ----------------------------------------------------------------------------
//  channel   handshake                 beat content
//  request   start / busy              req_mode, req_coin_kind, req_slot,
//                                      req_new_price, req_new_quantity
//  response  rsp_strobe (one cycle)    rsp_status, rsp_credit_left,
//                                      rsp_paid_kind, rsp_paid_count, rsp_last
//
//  Insert, buy, load, restock and unused modes: one response beat in the cycle
//  after the request beat; busy stays low, so requests may follow every cycle.
//  Give change: each denomination passes through the shared count unit in
//  turn, then one response beat per denomination follows on consecutive
//  cycles; busy drops in the cycle of the last beat.
//  Synchronous reset restores credit, coin stock and slot contents at once.
//  The receiver cannot stall; beats are never held.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vending_credit_and_change_controller #(
   parameter int SLOT_COUNT  = 16,
   parameter int DENOM_COUNT = 8
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [2:0]  req_mode,
   input  wire logic [3:0]  req_coin_kind,
   input  wire logic [3:0]  req_slot,
   input  wire logic [15:0] req_new_price,
   input  wire logic [7:0]  req_new_quantity,
   output logic             rsp_strobe,
   output logic [1:0]       rsp_status,
   output logic [15:0]      rsp_credit_left,
   output logic [3:0]       rsp_paid_kind,
   output logic [7:0]       rsp_paid_count,
   output logic             rsp_last
);
   import vcc_pkg::*;

   localparam int ACTIVE     = (DENOM_COUNT < TABLE_DENOMS) ? DENOM_COUNT : TABLE_DENOMS;
   localparam int DIDX_W     = (ACTIVE > 1) ? $clog2(ACTIVE) : 1;
   localparam int SLOT_DEPTH = (SLOT_COUNT < 16) ? SLOT_COUNT : 16;
   localparam int SLOT_W     = (SLOT_DEPTH > 1) ? $clog2(SLOT_DEPTH) : 1;
   localparam logic [DIDX_W-1:0] IDX_TOP = DIDX_W'(ACTIVE - 1);

   typedef enum logic [1:0] {ST_IDLE, ST_CALC, ST_EMIT} state_type;

   state_type          state_ff, state_in;
   logic [DIDX_W-1:0]  idx_ff, idx_in;
   logic               qstart_ff, qstart_in;
   logic [15:0]        credit_ff, credit_in;
   logic [7:0]         coin_stock_ff [ACTIVE];
   logic [7:0]         coin_stock_in [ACTIVE];
   logic [15:0]        price_ff [SLOT_DEPTH];
   logic [15:0]        price_in [SLOT_DEPTH];
   logic [7:0]         count_ff [SLOT_DEPTH];
   logic [7:0]         count_in [SLOT_DEPTH];
   logic [7:0]         paid_ff  [ACTIVE];
   logic [15:0]        after_ff [ACTIVE];

   logic               strobe_ff, strobe_in;
   logic [1:0]         status_ff, status_in;
   logic [15:0]        credit_left_ff, credit_left_in;
   logic [3:0]         paid_kind_ff, paid_kind_in;
   logic [7:0]         paid_count_ff, paid_count_in;
   logic               last_ff, last_in;

   logic               accept;
   logic               kind_ok;
   logic               slot_ok;
   logic [DIDX_W-1:0]  kidx;
   logic [DIDX_W-1:0]  stock_idx;
   logic [SLOT_W-1:0]  slot_idx;
   logic [7:0]         stock_rd;
   logic [15:0]        price_rd;
   logic [7:0]         count_rd;
   logic [9:0]         denom_rd;
   logic [16:0]        credit_sum;
   logic [15:0]        credit_after;

   qreq_type           qreq;
   qrsp_type           qrsp;

   vcc_quot_unit u_quot (
      .clock (clock),
      .reset (reset),
      .req   (qreq),
      .rsp   (qrsp)
   );

   always_comb begin
      accept    = start && !busy;
      kind_ok   = (req_coin_kind != 4'd0) && (req_coin_kind <= 4'(ACTIVE));
      slot_ok   = {5'd0, req_slot} < 9'(SLOT_COUNT);
      kidx      = DIDX_W'(req_coin_kind - 4'd1);
      stock_idx = (state_ff == ST_IDLE) ? kidx : idx_ff;
      slot_idx  = req_slot[SLOT_W-1:0];
      stock_rd  = coin_stock_ff[stock_idx];
      price_rd  = price_ff[slot_idx];
      count_rd  = count_ff[slot_idx];
      denom_rd  = denom_cents(3'(stock_idx));
      credit_sum   = {1'b0, credit_ff} + 17'(denom_rd);
      credit_after = credit_ff - qrsp.amount;

      qreq.start  = qstart_ff;
      qreq.credit = credit_ff;
      qreq.denom  = denom_rd;
      qreq.stock  = stock_rd;

      state_in      = state_ff;
      idx_in        = idx_ff;
      qstart_in     = 1'b0;
      credit_in     = credit_ff;
      coin_stock_in = coin_stock_ff;
      price_in      = price_ff;
      count_in      = count_ff;

      strobe_in      = 1'b0;
      status_in      = STATUS_OK;
      credit_left_in = credit_left_ff;
      paid_kind_in   = 4'd0;
      paid_count_in  = 8'd0;
      last_in        = 1'b1;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               strobe_in = 1'b1;
               case (req_mode)
                  MODE_INSERT: begin
                     if (kind_ok) begin
                        credit_in = credit_sum[16] ? CREDIT_MAX : credit_sum[15:0];
                        if (stock_rd < COUNT_MAX) begin
                           coin_stock_in[stock_idx] = stock_rd + 8'd1;
                        end
                     end
                  end
                  MODE_BUY: begin
                     if (!slot_ok || count_rd == 8'd0) begin
                        status_in = STATUS_SOLD_OUT;
                     end else if (credit_ff < price_rd) begin
                        status_in = STATUS_LOW_CREDIT;
                     end else begin
                        credit_in          = credit_ff - price_rd;
                        count_in[slot_idx] = count_rd - 8'd1;
                     end
                  end
                  MODE_CHANGE: begin
                     strobe_in = 1'b0;
                     state_in  = ST_CALC;
                     idx_in    = IDX_TOP;
                     qstart_in = 1'b1;
                  end
                  MODE_LOAD: begin
                     if (slot_ok) begin
                        price_in[slot_idx] = req_new_price;
                        count_in[slot_idx] = req_new_quantity;
                     end
                  end
                  MODE_RESTOCK: begin
                     if (kind_ok && stock_rd < COUNT_MAX) begin
                        coin_stock_in[stock_idx] = stock_rd + 8'd1;
                     end
                  end
                  default: begin
                  end
               endcase
               credit_left_in = credit_in;
            end
         end
         ST_CALC: begin
            if (qrsp.done) begin
               credit_in                = credit_after;
               coin_stock_in[stock_idx] = stock_rd - qrsp.count;
               if (idx_ff == '0) begin
                  state_in = ST_EMIT;
                  idx_in   = IDX_TOP;
               end else begin
                  idx_in    = idx_ff - DIDX_W'(1);
                  qstart_in = 1'b1;
               end
            end
         end
         ST_EMIT: begin
            strobe_in      = 1'b1;
            status_in      = (credit_ff != 16'd0) ? STATUS_SHORTFALL : STATUS_OK;
            credit_left_in = after_ff[idx_ff];
            paid_kind_in   = 4'(idx_ff) + 4'd1;
            paid_count_in  = paid_ff[idx_ff];
            last_in        = (idx_ff == '0);
            if (idx_ff == '0) begin
               state_in = ST_IDLE;
            end else begin
               idx_in = idx_ff - DIDX_W'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         idx_ff    <= '0;
         qstart_ff <= 1'b0;
         strobe_ff <= 1'b0;
         credit_ff <= 16'd0;
         for (int i = 0; i < ACTIVE; i++) begin
            coin_stock_ff[i] <= RESET_STOCK;
         end
         for (int i = 0; i < SLOT_DEPTH; i++) begin
            price_ff[i] <= (i == 0) ? RESET_PRICE_SLOT0 :
                           (i == 3) ? RESET_PRICE_SLOT3 : 16'd0;
            count_ff[i] <= (i == 0) ? RESET_COUNT_SLOT0 : 8'd0;
         end
      end else begin
         state_ff      <= state_in;
         idx_ff        <= idx_in;
         qstart_ff     <= qstart_in;
         strobe_ff     <= strobe_in;
         credit_ff     <= credit_in;
         coin_stock_ff <= coin_stock_in;
         price_ff      <= price_in;
         count_ff      <= count_in;
      end
      if (state_ff == ST_CALC && qrsp.done) begin
         paid_ff[idx_ff]  <= qrsp.count;
         after_ff[idx_ff] <= credit_after;
      end
      status_ff      <= status_in;
      credit_left_ff <= credit_left_in;
      paid_kind_ff   <= paid_kind_in;
      paid_count_ff  <= paid_count_in;
      last_ff        <= last_in;
   end

   assign busy            = (state_ff != ST_IDLE);
   assign rsp_strobe      = strobe_ff;
   assign rsp_status      = status_ff;
   assign rsp_credit_left = credit_left_ff;
   assign rsp_paid_kind   = paid_kind_ff;
   assign rsp_paid_count  = paid_count_ff;
   assign rsp_last        = last_ff;

endmodule

`default_nettype wire

FILE: design/vcc_checker.sv
// ----------------------------------------------------------------------------
// vcc_checker
// Port-level checks on request and response beats of the vending controller.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vcc_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       start,
   input wire logic       busy,
   input wire logic [2:0] req_mode,
   input wire logic       rsp_strobe,
   input wire logic [3:0] rsp_paid_kind,
   input wire logic [7:0] rsp_paid_count,
   input wire logic       rsp_last
);
   import vcc_pkg::*;

   a_single_beat: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_mode != MODE_CHANGE |=> rsp_strobe && rsp_last)
      else $error("single-beat request without a final response beat");

   a_plain_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_paid_kind == 4'd0 |-> rsp_last && rsp_paid_count == 8'd0)
      else $error("non-change beat carries payout or is not final");

   a_more_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_last |-> busy)
      else $error("idle while change beats remain");

   a_change_order: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_last |=>
         rsp_strobe && (rsp_paid_kind + 4'd1 == $past(rsp_paid_kind)))
      else $error("change beats not consecutive largest first");

endmodule

bind vending_credit_and_change_controller vcc_checker u_vcc_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .req_mode       (req_mode),
   .rsp_strobe     (rsp_strobe),
   .rsp_paid_kind  (rsp_paid_kind),
   .rsp_paid_count (rsp_paid_count),
   .rsp_last       (rsp_last)
);

`default_nettype wire
